// ----- src/cmvr_pkg.sv -----
// ----------------------------------------------------------------------------
// cmvr_pkg
// Types and constants shared by the center-of-mass velocity removal unit.
// ----------------------------------------------------------------------------
package cmvr_pkg;

  localparam int MAX_ATOMS   = 64;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int CNT_W       = 7;

  localparam int MASS_W  = 24;
  localparam int VEL_W   = 32;
  localparam int PROD_W  = 57;
  localparam int MOM_W   = 64;
  localparam int TMASS_W = 30;

  localparam int DIV_STEPS  = 64;
  localparam int DIV_CNT_W  = 7;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int Q_CNT_W  = 3;

  localparam int RAM_W = 1 + 3 * VEL_W;

  typedef logic [2:0][VEL_W-1:0] vel3_t;
  typedef logic [2:0][MOM_W-1:0] mom3_t;

  typedef struct packed {
    logic [MASS_W-1:0]       mass;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic                    last_atom;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       atom_index;
    logic signed [VEL_W-1:0] out_vel_x;
    logic signed [VEL_W-1:0] out_vel_y;
    logic signed [VEL_W-1:0] out_vel_z;
    logic                    last_result;
    logic                    dropped_atoms;
  } out_item_t;

  // classified atom between front and back
  typedef struct packed {
    logic              stored;
    logic              last;
    logic [MASS_W-1:0] mass;
    vel3_t             vel;
  } iq_entry_t;

  typedef struct packed {
    logic  done;
    vel3_t quo;
  } div_res_t;

  typedef enum logic [2:0] {
    BK_LOAD,
    BK_FLUSH,
    BK_DIV_GO,
    BK_DIV_WAIT,
    BK_EMIT
  } back_state_t;

endpackage

// ----- src/cmvr_ram.sv -----
// ----------------------------------------------------------------------------
// cmvr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ----- src/cmvr_front.sv -----
// ----------------------------------------------------------------------------
// cmvr_front
// Accepts atoms, marks them stored or dropped, and queues them for the back.
// ----------------------------------------------------------------------------
module cmvr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  cmvr_pkg::in_item_t   in_item,
  input  logic                 iq_pop,
  output logic                 iq_vld,
  output cmvr_pkg::iq_entry_t  iq_entry
);
  import cmvr_pkg::*;

  logic [CNT_W-1:0]    fc_r, fc_nxt;
  logic [IQ_PTR_W-1:0] wp_r, rp_r;
  logic [Q_CNT_W-1:0]  occ_r, occ_nxt;
  iq_entry_t           mem_r [IQ_DEPTH];
  iq_entry_t           new_entry;
  logic                accept, pop;

  assign in_full  = (occ_r == Q_CNT_W'(IQ_DEPTH));
  assign iq_vld   = (occ_r != '0);
  assign accept   = in_push && !in_full;
  assign pop      = iq_pop && iq_vld;
  assign iq_entry = mem_r[rp_r];

  always_comb begin
    new_entry.stored = (fc_r < CNT_W'(MAX_ATOMS));
    new_entry.last   = in_item.last_atom;
    new_entry.mass   = in_item.mass;
    new_entry.vel    = {in_item.vel_z, in_item.vel_y, in_item.vel_x};
  end

  always_comb begin
    fc_nxt = fc_r;
    if (accept) begin
      if (in_item.last_atom) begin
        fc_nxt = '0;
      end else if (new_entry.stored) begin
        fc_nxt = fc_r + 1'b1;
      end
    end
    occ_nxt = occ_r + Q_CNT_W'(accept) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r  <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
      occ_r <= '0;
    end else begin
      fc_r  <= fc_nxt;
      occ_r <= occ_nxt;
      if (accept) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wp_r] <= new_entry;
    end
  end

endmodule

// ----- src/cmvr_div.sv -----
// ----------------------------------------------------------------------------
// cmvr_div
// Three-lane restoring divider: signed momentum over total mass, one quotient
// bit per lane per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module cmvr_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  cmvr_pkg::mom3_t                 num,
  input  logic [cmvr_pkg::TMASS_W-1:0]    den,
  output cmvr_pkg::div_res_t              res
);
  import cmvr_pkg::*;

  logic                        busy_r, done_r;
  logic [DIV_CNT_W-1:0]        step_r;
  logic [TMASS_W-1:0]          den_r;
  logic [2:0]                  neg_r;
  logic [2:0][MOM_W-1:0]       q_r, q_nxt, mag;
  logic [2:0][TMASS_W-1:0]     rem_r, rem_nxt;
  logic [2:0][TMASS_W:0]       trial;
  logic [2:0]                  ge;
  logic [2:0][VEL_W:0]         q33;
  vel3_t                       quo_r, quo_nxt;

  assign res.done = done_r;
  assign res.quo  = quo_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]     = num[i][MOM_W-1] ? (~num[i] + 1'b1) : num[i];
      trial[i]   = {rem_r[i], q_r[i][MOM_W-1]};
      ge[i]      = (trial[i] >= {1'b0, den_r});
      rem_nxt[i] = ge[i] ? TMASS_W'(trial[i] - {1'b0, den_r}) : trial[i][TMASS_W-1:0];
      q_nxt[i]   = {q_r[i][MOM_W-2:0], ge[i]};
      q33[i]     = neg_r[i] ? (~q_r[i][VEL_W:0] + 1'b1) : q_r[i][VEL_W:0];
      quo_nxt[i] = q33[i][VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == DIV_CNT_W'(DIV_STEPS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= num[i][MOM_W-1];
        q_r[i]   <= mag[i];
        rem_r[i] <= '0;
      end
    end else if (busy_r) begin
      if (step_r == DIV_CNT_W'(DIV_STEPS)) begin
        quo_r <= quo_nxt;
      end else begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

endmodule

// ----- src/cmvr_back.sv -----
// ----------------------------------------------------------------------------
// cmvr_back
// Stores atoms, accumulates momentum and mass, runs the divide, then emits the
// corrected velocities through a small result queue.
// ----------------------------------------------------------------------------
module cmvr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          iq_vld,
  input  cmvr_pkg::iq_entry_t           iq_entry,
  output logic                          iq_pop,
  output logic                          div_start,
  output cmvr_pkg::mom3_t               div_num,
  output logic [cmvr_pkg::TMASS_W-1:0]  div_den,
  input  cmvr_pkg::div_res_t            div_res,
  output logic                          out_empty,
  input  logic                          out_pop,
  output cmvr_pkg::out_item_t           out_item
);
  import cmvr_pkg::*;

  back_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r;
  logic                      ovf_r;
  logic [TMASS_W-1:0]        tmass_r;
  mom3_t                     acc_r;
  logic [2:0][PROD_W-1:0]    prod_r;
  logic signed [PROD_W-1:0]  prod_x, prod_y, prod_z;
  logic                      prod_vld_r;
  logic [MASS_W-1:0]         mass_r;
  logic [ADDR_W-1:0]         k_r;
  logic                      issue, last_issue, clear_set;

  logic                      rd_vld_r, rd_last_r, rd_ovf_r, rd_mz_r;
  logic [ADDR_W-1:0]         rd_idx_r;
  logic [RAM_W-1:0]          rd_data;
  logic                      rd_virt;
  vel3_t                     rd_vel, corr;
  logic [2:0][VEL_W-1:0]     cvel;
  logic [2:0][VEL_W:0]       diff;

  out_item_t                 oq_r [OQ_DEPTH];
  out_item_t                 res_item;
  logic [OQ_PTR_W-1:0]       oq_wp_r, oq_rp_r;
  logic [Q_CNT_W-1:0]        oq_cnt_r;
  logic                      oq_pop;

  assign div_num = acc_r;
  assign div_den = tmass_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_LOAD:     if (iq_vld && iq_entry.last) state_nxt = BK_FLUSH;
      BK_FLUSH:    state_nxt = BK_DIV_GO;
      BK_DIV_GO:   state_nxt = BK_DIV_WAIT;
      BK_DIV_WAIT: if (div_res.done) state_nxt = BK_EMIT;
      BK_EMIT:     if (issue && last_issue) state_nxt = BK_LOAD;
      default:     state_nxt = BK_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    iq_pop    = 1'b0;
    div_start = 1'b0;
    issue     = 1'b0;
    unique case (state_r)
      BK_LOAD:     iq_pop = iq_vld;
      BK_FLUSH:    ;
      BK_DIV_GO:   div_start = 1'b1;
      BK_DIV_WAIT: ;
      BK_EMIT:     issue = (({1'b0, oq_cnt_r} + (Q_CNT_W+1)'(rd_vld_r))
                            < (Q_CNT_W+1)'(OQ_DEPTH));
      default:     ;
    endcase
  end

  assign last_issue = ({1'b0, k_r} == (cnt_r - 1'b1));
  assign clear_set  = issue && last_issue;

  assign prod_x = $signed({1'b0, iq_entry.mass}) * $signed(iq_entry.vel[0]);
  assign prod_y = $signed({1'b0, iq_entry.mass}) * $signed(iq_entry.vel[1]);
  assign prod_z = $signed({1'b0, iq_entry.mass}) * $signed(iq_entry.vel[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_LOAD;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      tmass_r    <= '0;
      acc_r      <= '0;
      prod_vld_r <= 1'b0;
      k_r        <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prod_vld_r <= iq_pop && iq_entry.stored && (iq_entry.mass != '0);
      rd_vld_r   <= issue;
      if (iq_pop) begin
        if (iq_entry.stored) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (prod_vld_r) begin
        tmass_r <= tmass_r + TMASS_W'(mass_r);
        for (int i = 0; i < 3; i++) begin
          acc_r[i] <= acc_r[i]
                    + {{(MOM_W-PROD_W){prod_r[i][PROD_W-1]}}, prod_r[i]};
        end
      end
      if (issue) begin
        k_r <= last_issue ? '0 : k_r + 1'b1;
      end
      if (clear_set) begin
        cnt_r   <= '0;
        ovf_r   <= 1'b0;
        tmass_r <= '0;
        acc_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r[0] <= prod_x;
    prod_r[1] <= prod_y;
    prod_r[2] <= prod_z;
    mass_r    <= iq_entry.mass;
    if (issue) begin
      rd_idx_r  <= k_r;
      rd_last_r <= last_issue;
      rd_ovf_r  <= ovf_r;
      rd_mz_r   <= (tmass_r == '0);
    end
  end

  cmvr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (iq_pop && iq_entry.stored),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data ({(iq_entry.mass == '0), iq_entry.vel}),
    .rd_en   (issue),
    .rd_addr (k_r),
    .rd_data (rd_data)
  );

  assign rd_virt = rd_data[RAM_W-1];
  assign rd_vel  = rd_data[RAM_W-2:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cvel[i] = (rd_virt || rd_mz_r) ? '0 : div_res.quo[i];
      diff[i] = {rd_vel[i][VEL_W-1], rd_vel[i]} - {cvel[i][VEL_W-1], cvel[i]};
      if (diff[i][VEL_W] != diff[i][VEL_W-1]) begin
        corr[i] = diff[i][VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
      end else begin
        corr[i] = diff[i][VEL_W-1:0];
      end
    end
    res_item.atom_index    = rd_idx_r;
    res_item.out_vel_x     = corr[0];
    res_item.out_vel_y     = corr[1];
    res_item.out_vel_z     = corr[2];
    res_item.last_result   = rd_last_r;
    res_item.dropped_atoms = rd_ovf_r;
  end

  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_item  = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_r + Q_CNT_W'(rd_vld_r) - Q_CNT_W'(oq_pop);
      if (rd_vld_r) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      oq_r[oq_wp_r] <= res_item;
    end
  end

endmodule

// ----- src/center_of_mass_velocity_removal_unit.sv -----
// ----------------------------------------------------------------------------
// center_of_mass_velocity_removal_unit
// Removes the center-of-mass velocity from a set of up to 64 atoms.
//
//   channel   ports                        transfer when
//   atoms     in_push, in_full, in_item    in_push && !in_full
//   results   out_empty, out_pop, out_item out_pop && !out_empty
//
// Atoms load at one per cycle while the back end is loading, through a 4-entry
// queue into the store. After the last atom transfers, the sums settle, the
// three-lane bit-serial divider runs, the stored velocities are read back, and
// then results leave at one per cycle while out_pop keeps up.
// in_full rises once the queue holds 4 atoms during divide and emission.
// Reset clears control state and the sums; the store and queues hold no reset value.
// ----------------------------------------------------------------------------
module center_of_mass_velocity_removal_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  cmvr_pkg::in_item_t   in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output cmvr_pkg::out_item_t  out_item
);
  import cmvr_pkg::*;

  logic               iq_vld, iq_pop, div_start;
  iq_entry_t          iq_entry;
  mom3_t              div_num;
  logic [TMASS_W-1:0] div_den;
  div_res_t           div_res;

  cmvr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .iq_pop   (iq_pop),
    .iq_vld   (iq_vld),
    .iq_entry (iq_entry)
  );

  cmvr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  cmvr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .iq_vld    (iq_vld),
    .iq_entry  (iq_entry),
    .iq_pop    (iq_pop),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_res   (div_res),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ----- src/cmvr_chk.sv -----
// ----------------------------------------------------------------------------
// cmvr_chk
// Port-level checks on the result stream of the velocity removal unit.
// ----------------------------------------------------------------------------
module cmvr_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_empty,
  input logic                 out_pop,
  input cmvr_pkg::out_item_t  out_item
);
  import cmvr_pkg::*;

  logic              out_xfer;
  logic [ADDR_W-1:0] exp_idx_r;
  logic              mid_r, drop_r;

  assign out_xfer = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
      mid_r     <= 1'b0;
      drop_r    <= 1'b0;
    end else if (out_xfer) begin
      exp_idx_r <= out_item.last_result ? '0 : out_item.atom_index + 1'b1;
      mid_r     <= !out_item.last_result;
      drop_r    <= out_item.dropped_atoms;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("results present right after reset");

  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> out_item.atom_index == exp_idx_r)
    else $error("atom index out of order");

  a_drop_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && mid_r |-> out_item.dropped_atoms == drop_r)
    else $error("dropped flag changed within a set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting result changed or vanished");

endmodule

bind center_of_mass_velocity_removal_unit cmvr_chk u_chk (.*);

// ----- verif/center_of_mass_velocity_removal_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// center_of_mass_velocity_removal_unit_test
// Drives atom sets into the unit and predicts each corrected velocity.
// The sets cover pure virtual sites, saturation and rounding cases, and one
// oversized set that drops atoms. Both queue sides idle and stall at random,
// and one long receiver stall backs the unit up into its input.
// ----------------------------------------------------------------------------
module center_of_mass_velocity_removal_unit_test;
  import cmvr_pkg::*;

  localparam logic [31:0] VMAX = 32'h7fff_ffff;
  localparam logic [31:0] VMIN = 32'h8000_0000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int STALL_TRIGGER = 30;
  localparam int STALL_LEN = 400;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;

  in_item_t atom_queue[$];
  out_item_t corrected_due[$];

  logic signed [VEL_W-1:0] held_vx[STORE_DEPTH];
  logic signed [VEL_W-1:0] held_vy[STORE_DEPTH];
  logic signed [VEL_W-1:0] held_vz[STORE_DEPTH];
  bit held_virtual[STORE_DEPTH];
  longint mom_x = 0;
  longint mom_y = 0;
  longint mom_z = 0;
  logic [TMASS_W-1:0] mass_total = '0;
  int held_count = 0;
  bit drop_seen = 1'b0;

  int send_idle_pct = 18;
  int pop_idle_pct = 46;
  int atoms_sent = 0;
  int error_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  center_of_mass_velocity_removal_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  function automatic logic signed [VEL_W-1:0] clamp_vel(longint v);
    if (v > 64'sd2147483647) return VMAX;
    if (v < -64'sd2147483648) return VMIN;
    return v[VEL_W-1:0];
  endfunction

  task automatic predict_corrected_atoms(input in_item_t a);
    out_item_t r;
    longint cx, cy, cz, sx, sy, sz;
    if (held_count < MAX_ATOMS) begin
      held_vx[held_count] = a.vel_x;
      held_vy[held_count] = a.vel_y;
      held_vz[held_count] = a.vel_z;
      held_virtual[held_count] = (a.mass == '0);
      if (a.mass != '0) begin
        mom_x += longint'(a.mass) * longint'(a.vel_x);
        mom_y += longint'(a.mass) * longint'(a.vel_y);
        mom_z += longint'(a.mass) * longint'(a.vel_z);
        mass_total = mass_total + TMASS_W'(a.mass);
      end
      held_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!a.last_atom) return;
    cx = 0;
    cy = 0;
    cz = 0;
    if (mass_total != '0) begin
      cx = mom_x / longint'(mass_total);
      cy = mom_y / longint'(mass_total);
      cz = mom_z / longint'(mass_total);
    end
    for (int k = 0; k < held_count; k++) begin
      sx = longint'(held_vx[k]);
      sy = longint'(held_vy[k]);
      sz = longint'(held_vz[k]);
      if (!held_virtual[k] && mass_total != '0) begin
        sx -= cx;
        sy -= cy;
        sz -= cz;
      end
      r.atom_index = k[ADDR_W-1:0];
      r.out_vel_x = clamp_vel(sx);
      r.out_vel_y = clamp_vel(sy);
      r.out_vel_z = clamp_vel(sz);
      r.last_result = (k + 1 == held_count);
      r.dropped_atoms = drop_seen;
      corrected_due.push_back(r);
    end
    mom_x = 0;
    mom_y = 0;
    mom_z = 0;
    mass_total = '0;
    held_count = 0;
    drop_seen = 1'b0;
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, field, got, want);
  endtask

  task automatic check_corrected(input out_item_t got);
    out_item_t want;
    if (corrected_due.size() == 0) begin
      report_mismatch("unexpected transfer", 64'(got), 64'd0);
      return;
    end
    want = corrected_due.pop_front();
    if (got.atom_index != want.atom_index)
      report_mismatch("atom_index", 64'(got.atom_index), 64'(want.atom_index));
    if (got.out_vel_x != want.out_vel_x)
      report_mismatch("out_vel_x", 64'(got.out_vel_x), 64'(want.out_vel_x));
    if (got.out_vel_y != want.out_vel_y)
      report_mismatch("out_vel_y", 64'(got.out_vel_y), 64'(want.out_vel_y));
    if (got.out_vel_z != want.out_vel_z)
      report_mismatch("out_vel_z", 64'(got.out_vel_z), 64'(want.out_vel_z));
    if (got.last_result != want.last_result)
      report_mismatch("last_result", 64'(got.last_result), 64'(want.last_result));
    if (got.dropped_atoms != want.dropped_atoms)
      report_mismatch("dropped_atoms", 64'(got.dropped_atoms), 64'(want.dropped_atoms));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_corrected_atoms(in_item);
        atoms_sent++;
      end
      if (!in_push || !in_full) begin
        if (atom_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= atom_queue.pop_front();
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && atoms_sent >= STALL_TRIGGER) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_corrected(out_item);
      out_pop <= (stall_left == 0) && ($urandom_range(99) >= pop_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL center_of_mass_velocity_removal_unit");
      $finish;
    end
  end

  task automatic add_atom(input logic [MASS_W-1:0] m, input logic [VEL_W-1:0] vx,
                          input logic [VEL_W-1:0] vy, input logic [VEL_W-1:0] vz,
                          input bit last);
    in_item_t a;
    a.mass = m;
    a.vel_x = vx;
    a.vel_y = vy;
    a.vel_z = vz;
    a.last_atom = last;
    atom_queue.push_back(a);
  endtask

  function automatic logic [VEL_W-1:0] random_vel();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return VMAX;
    if (pick < 20) return VMIN;
    if (pick < 50) return $urandom_range(2097152) - 1048576;
    return $urandom;
  endfunction

  function automatic logic [MASS_W-1:0] random_mass();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 25) return '1;
    if (pick < 45) return MASS_W'($urandom_range(255, 1));
    return MASS_W'($urandom);
  endfunction

  task automatic queue_random_sets(input int n_items, input int big_size);
    int queued, size;
    queued = 0;
    if (big_size != 0) begin
      for (int k = 0; k < big_size; k++)
        add_atom(random_mass(), random_vel(), random_vel(), random_vel(), k == big_size - 1);
    end
    while (queued < n_items) begin
      size = $urandom_range(6, 1);
      for (int k = 0; k < size; k++)
        add_atom(random_mass(), random_vel(), random_vel(), random_vel(), k == size - 1);
      queued += size;
    end
  endtask

  task automatic wait_sent();
    while (atom_queue.size() != 0 || in_push) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // lone heaviest atom at the velocity extremes
    add_atom('1, VMIN, VMAX, 32'd0, 1'b1);
    // only virtual sites: zero total mass
    add_atom('0, 32'd123, -32'sd5, VMAX, 1'b0);
    add_atom('0, VMIN, 32'd1, -32'sd1, 1'b1);
    // saturation both ways, virtual site left alone
    add_atom('1, VMAX, VMIN, VMAX, 1'b0);
    add_atom('0, VMIN, VMAX, -32'sd7, 1'b0);
    add_atom(24'd1, VMIN, VMAX, -32'sd1000, 1'b1);
    // small masses, truncation toward zero on negative momentum
    add_atom(24'd1, -32'sd3, 32'sd5, -32'sd7, 1'b0);
    add_atom(24'd2, 32'sd0, -32'sd1, 32'sd1, 1'b0);
    add_atom(24'd3, 32'sd1, 32'sd1, -32'sd1, 1'b0);
    add_atom(24'h000100, -32'sd1000000, 32'sd2000000, 32'sd333, 1'b1);
    // virtual site first, heavy atoms after
    add_atom('0, VMAX, VMAX, VMAX, 1'b0);
    add_atom(24'h800000, 32'h4000_0000, 32'hc000_0000, 32'd12345, 1'b0);
    add_atom(24'h7fffff, $urandom, $urandom, $urandom, 1'b1);
    wait_sent();
    while (corrected_due.size() != 0) @(negedge clk);

    queue_random_sets(24, 0);
    wait_sent();

    send_idle_pct = 46;
    pop_idle_pct = 18;
    queue_random_sets(6, 66);
    wait_sent();

    send_idle_pct = 0;
    pop_idle_pct = 0;
    queue_random_sets(20, 0);
    wait_sent();

    while (corrected_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS center_of_mass_velocity_removal_unit");
    end else begin
      $display("FAIL center_of_mass_velocity_removal_unit");
    end
    $finish;
  end

endmodule
